FILE: rtl/fmfp_pkg.sv
// Shared types, constants and helpers for the meter frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package fmfp_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int VOL_W       = 51;
	localparam int FLOW_W      = 29;
	localparam int TEMP_W      = 21;

	localparam logic [7:0] START_A     = 8'h3C;
	localparam logic [7:0] START_B     = 8'h32;
	localparam logic [7:0] STOP_BYTE   = 8'h16;
	localparam logic [7:0] FLAG_VOL    = 8'h0B;
	localparam logic [7:0] FLAG_FLOW   = 8'h0C;
	localparam logic [7:0] FLAG_TEMP   = 8'h0D;
	localparam logic [7:0] UNIT_M3     = 8'h1A;
	localparam logic [7:0] SIGN_NEG    = 8'h80;
	localparam logic [7:0] TEMP_BLANK  = 8'h70;

	localparam int BIT_EMPTY = 5;
	localparam int BIT_CHIP  = 5;
	localparam int BIT_DIR   = 3;
	localparam int BIT_RANGE = 2;

	// byte positions in a frame
	localparam logic [ADDR_W-1:0] POS_START_B = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] POS_UNIT    = ADDR_W'(8);
	localparam logic [ADDR_W-1:0] POS_VOL_LO  = ADDR_W'(9);
	localparam logic [ADDR_W-1:0] POS_VOL_HI  = ADDR_W'(14);
	localparam logic [ADDR_W-1:0] POS_FLAG_V  = ADDR_W'(15);
	localparam logic [ADDR_W-1:0] POS_FLOW_LO = ADDR_W'(16);
	localparam logic [ADDR_W-1:0] POS_FLOW_HI = ADDR_W'(19);
	localparam logic [ADDR_W-1:0] POS_SIGN    = ADDR_W'(20);
	localparam logic [ADDR_W-1:0] POS_FLAG_F  = ADDR_W'(21);
	localparam logic [ADDR_W-1:0] POS_FLAG_T  = ADDR_W'(24);
	localparam logic [ADDR_W-1:0] POS_TEMP_LO = ADDR_W'(25);
	localparam logic [ADDR_W-1:0] POS_TEMP_MD = ADDR_W'(26);
	localparam logic [ADDR_W-1:0] POS_TEMP_HI = ADDR_W'(27);
	localparam logic [ADDR_W-1:0] POS_STAT1   = ADDR_W'(28);
	localparam logic [ADDR_W-1:0] POS_STAT2   = ADDR_W'(29);
	localparam logic [ADDR_W-1:0] POS_CSUM    = ADDR_W'(30);
	localparam logic [ADDR_W-1:0] POS_LAST    = ADDR_W'(FRAME_BYTES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_SHIFT
	} fmfp_state_t;

	typedef struct packed {
		logic wr_byte;
		logic fill_clear;
		logic fill_inc;
		logic fill_resync;
		logic scan_start;
		logic shift_start;
		logic load_out;
	} fmfp_cmd_t;

	typedef struct packed {
		logic byte_drop;
		logic frame_full;
		logic scan_done;
		logic shift_done;
		logic frame_ok;
		logic found;
		logic out_busy;
	} fmfp_sts_t;

	// high nibble * 10 + low nibble, non-BCD nibbles at face value
	function automatic logic [7:0] bcd_val(input logic [7:0] b);
		return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/flow_meter_frame_parser_top.sv
// Meter frame parser: one byte per request in, one decoded frame per request out.
// A byte that does not complete a frame is written into the buffer while idle. The closing byte
// starts a sweep of the 32-byte buffer followed by a check state; a failed frame with a
// later start pair then copies the bytes from that pair onward to the buffer start.
// Reset (arst_n low) clears control state; the frame buffer is not cleared.
`default_nettype none

module flow_meter_frame_parser_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fmfp_pkg::VOL_W-1:0]         total_volume,
	output logic signed [fmfp_pkg::FLOW_W-1:0] flow_rate,
	output logic                               flow_valid,
	output logic [fmfp_pkg::TEMP_W-1:0]        temperature,
	output logic                               temperature_valid,
	output logic                               tube_dry,
	output logic                               chip_error,
	output logic                               direction_wrong,
	output logic                               rate_out_of_range
);
	import fmfp_pkg::*;

	fmfp_cmd_t cmd;
	fmfp_sts_t sts;

	fmfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fmfp_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.rx_byte           (rx_byte),
		.cmd               (cmd),
		.sts               (sts),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.total_volume      (total_volume),
		.flow_rate         (flow_rate),
		.flow_valid        (flow_valid),
		.temperature       (temperature),
		.temperature_valid (temperature_valid),
		.tube_dry          (tube_dry),
		.chip_error        (chip_error),
		.direction_wrong   (direction_wrong),
		.rate_out_of_range (rate_out_of_range)
	);

endmodule

`default_nettype wire

FILE: rtl/fmfp_ctrl.sv
// Controller state machine for the meter frame parser.
// Depends on fmfp_pkg; drives commands into fmfp_dp and reads its status.
`default_nettype none

module fmfp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  fmfp_pkg::fmfp_sts_t     sts,
	output fmfp_pkg::fmfp_cmd_t     cmd
);
	import fmfp_pkg::*;

	fmfp_state_t state_q, state_nxt;
	logic        accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !sts.byte_drop && sts.frame_full) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.frame_ok) begin
					if (!sts.out_busy) begin
						state_nxt = ST_IDLE;
					end
				end else if (sts.found) begin
					state_nxt = ST_SHIFT;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (sts.shift_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_byte = accept;
				if (accept) begin
					if (sts.byte_drop) begin
						cmd.fill_clear = 1'b1;
					end else if (sts.frame_full) begin
						cmd.scan_start = 1'b1;
					end else begin
						cmd.fill_inc = 1'b1;
					end
				end
			end
			ST_SCAN: begin
			end
			ST_CHECK: begin
				if (sts.frame_ok) begin
					if (!sts.out_busy) begin
						cmd.load_out   = 1'b1;
						cmd.fill_clear = 1'b1;
					end
				end else if (sts.found) begin
					cmd.shift_start = 1'b1;
				end else begin
					cmd.fill_clear = 1'b1;
				end
			end
			ST_SHIFT: begin
				cmd.fill_resync = sts.shift_done;
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/fmfp_dp.sv
// Datapath of the meter frame parser: frame buffer, sweep counter, checks,
// BCD accumulators and result register. Depends on fmfp_pkg; run by fmfp_ctrl.
`default_nettype none

module fmfp_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    rx_byte,
	input  fmfp_pkg::fmfp_cmd_t                cmd,
	output fmfp_pkg::fmfp_sts_t                sts,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [fmfp_pkg::VOL_W-1:0]         total_volume,
	output logic signed [fmfp_pkg::FLOW_W-1:0] flow_rate,
	output logic                               flow_valid,
	output logic [fmfp_pkg::TEMP_W-1:0]        temperature,
	output logic                               temperature_valid,
	output logic                               tube_dry,
	output logic                               chip_error,
	output logic                               direction_wrong,
	output logic                               rate_out_of_range
);
	import fmfp_pkg::*;

	logic [7:0]        mem_q [FRAME_BYTES];
	logic [ADDR_W-1:0] fill_q;

	logic              run_q, dir_dn_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [7:0]        rd_data_s1;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	logic [VOL_W-1:0]  vol_acc_q;
	logic [FLOW_W-1:0] flow_acc_q;
	logic [TEMP_W-1:0] temp_acc_q;
	logic [7:0]        sum_q, csum_q, prev_q;
	logic              flags_ok_q, blank_q, found_q;
	logic [ADDR_W-1:0] pos_q;
	logic              m3_q, neg_q, empty_q, chip_q, dir_q, range_q;

	logic              scan_vld, shift_vld;
	logic [7:0]        d;
	logic [ADDR_W-1:0] a;
	logic [7:0]        dv;

	logic              out_valid_q;
	logic [VOL_W-1:0]  vol_x1000;
	logic [FLOW_W-1:0] flow_signed;

	assign d         = rd_data_s1;
	assign a         = rd_addr_s1;
	assign dv        = bcd_val(d);
	assign scan_vld  = rd_vld_s1 && dir_dn_q;
	assign shift_vld = rd_vld_s1 && !dir_dn_q;

	// input write, or the shifted byte during resync
	always_comb begin
		wr_en   = cmd.wr_byte || shift_vld;
		wr_addr = fill_q;
		wr_data = rx_byte;
		if (shift_vld) begin
			wr_addr = a - pos_q;
			wr_data = d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (run_q) begin
			rd_data_s1 <= mem_q[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			run_q       <= 1'b0;
			dir_dn_q    <= 1'b1;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_addr_s1  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_clear) begin
				fill_q <= '0;
			end else if (cmd.fill_inc) begin
				fill_q <= fill_q + ADDR_W'(1);
			end else if (cmd.fill_resync) begin
				fill_q <= '0 - pos_q;
			end

			if (cmd.scan_start) begin
				run_q    <= 1'b1;
				dir_dn_q <= 1'b1;
				cnt_q    <= POS_LAST;
			end else if (cmd.shift_start) begin
				run_q    <= 1'b1;
				dir_dn_q <= 1'b0;
				cnt_q    <= pos_q;
			end else if (run_q) begin
				if (dir_dn_q ? (cnt_q == '0) : (cnt_q == POS_LAST)) begin
					run_q <= 1'b0;
				end else if (dir_dn_q) begin
					cnt_q <= cnt_q - ADDR_W'(1);
				end else begin
					cnt_q <= cnt_q + ADDR_W'(1);
				end
			end
			rd_vld_s1  <= run_q;
			rd_addr_s1 <= cnt_q;

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sweep runs from the last byte down, so each value is built most
	// significant pair first and the last start pair seen is the earliest
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			vol_acc_q  <= '0;
			flow_acc_q <= '0;
			temp_acc_q <= '0;
			sum_q      <= '0;
			flags_ok_q <= 1'b1;
			blank_q    <= 1'b1;
			found_q    <= 1'b0;
		end else if (scan_vld) begin
			prev_q <= d;
			if (a < POS_CSUM) begin
				sum_q <= sum_q + d;
			end
			if (a >= ADDR_W'(2) && a < POS_LAST && d == START_A && prev_q == START_B) begin
				found_q <= 1'b1;
				pos_q   <= a;
			end
			if (a inside {[POS_VOL_LO:POS_VOL_HI]}) begin
				vol_acc_q <= (vol_acc_q << 6) + (vol_acc_q << 5) + (vol_acc_q << 2)
					+ VOL_W'(dv);
			end
			if (a inside {[POS_FLOW_LO:POS_FLOW_HI]}) begin
				flow_acc_q <= (flow_acc_q << 6) + (flow_acc_q << 5) + (flow_acc_q << 2)
					+ FLOW_W'(dv);
			end
			if (a inside {[POS_TEMP_LO:POS_TEMP_HI]}) begin
				temp_acc_q <= (temp_acc_q << 6) + (temp_acc_q << 5) + (temp_acc_q << 2)
					+ TEMP_W'(dv);
			end
			case (a)
				'0:          flags_ok_q <= flags_ok_q && (d == START_A);
				POS_START_B: flags_ok_q <= flags_ok_q && (d == START_B);
				POS_UNIT:    m3_q <= (d == UNIT_M3);
				POS_FLAG_V:  flags_ok_q <= flags_ok_q && (d == FLAG_VOL);
				POS_SIGN:    neg_q <= (d == SIGN_NEG);
				POS_FLAG_F:  flags_ok_q <= flags_ok_q && (d == FLAG_FLOW);
				POS_FLAG_T:  flags_ok_q <= flags_ok_q && (d == FLAG_TEMP);
				POS_TEMP_LO: blank_q <= blank_q && (d == 8'h00);
				POS_TEMP_MD: blank_q <= blank_q && (d == 8'h00 || d == TEMP_BLANK);
				POS_TEMP_HI: blank_q <= blank_q && (d == 8'h00);
				POS_STAT1:   empty_q <= d[BIT_EMPTY];
				POS_STAT2: begin
					chip_q  <= d[BIT_CHIP];
					dir_q   <= d[BIT_DIR];
					range_q <= d[BIT_RANGE];
				end
				POS_CSUM:    csum_q <= d;
				POS_LAST:    flags_ok_q <= flags_ok_q && (d == STOP_BYTE);
				default:     ;
			endcase
		end
	end

	// x1000 = x1024 - x16 - x8
	assign vol_x1000   = (vol_acc_q << 10) - (vol_acc_q << 4) - (vol_acc_q << 3);
	assign flow_signed = neg_q ? ('0 - flow_acc_q) : flow_acc_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			total_volume      <= m3_q ? vol_x1000 : vol_acc_q;
			flow_rate         <= empty_q ? '0 : $signed(flow_signed);
			flow_valid        <= !empty_q;
			temperature       <= (empty_q || blank_q) ? '0 : temp_acc_q;
			temperature_valid <= !(empty_q || blank_q);
			tube_dry          <= empty_q;
			chip_error        <= chip_q;
			direction_wrong   <= dir_q;
			rate_out_of_range <= range_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts            = '0;
		sts.byte_drop  = (fill_q == '0 && rx_byte != START_A)
			|| (fill_q == POS_START_B && rx_byte != START_B);
		sts.frame_full = (fill_q == POS_LAST);
		sts.scan_done  = scan_vld && (a == '0);
		sts.shift_done = shift_vld && (a == POS_LAST);
		sts.frame_ok   = flags_ok_q && (sum_q == csum_q);
		sts.found      = found_q;
		sts.out_busy   = out_valid_q && !out_ready;
	end

endmodule

`default_nettype wire

FILE: rtl/fmfp_chk.sv
// Port-level checker for the meter frame parser, bound to the top level.
// Depends on fmfp_pkg for field widths.
`default_nettype none

module fmfp_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [fmfp_pkg::VOL_W-1:0]    total_volume,
	input wire logic [fmfp_pkg::FLOW_W-1:0]   flow_rate,
	input wire logic                          flow_valid,
	input wire logic [fmfp_pkg::TEMP_W-1:0]   temperature,
	input wire logic                          temperature_valid,
	input wire logic                          tube_dry
);
	import fmfp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_volume))
		else $error("result dropped or changed while stalled");

	a_empty_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tube_dry == !flow_valid))
		else $error("flow_valid does not follow empty tube");

	a_flow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !flow_valid |-> flow_rate == '0)
		else $error("invalid flow not zero");

	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tube_dry || !temperature_valid) |->
			temperature == '0 && !temperature_valid)
		else $error("invalid temperature not cleared");

endmodule

bind flow_meter_frame_parser_top fmfp_chk u_fmfp_chk (.*);

`default_nettype wire
